>>> rtl/assert_macros.svh
// Assertion helpers for the checker in etok_checker.sv.
// Each use expects i_clk and i_rst_n in scope; checks are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property
`define AST_CHK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("etok check failed");

// Condition now implies a property in the next cycle
`define AST_NEXT(lbl, pre, post) `AST_CHK(lbl, (pre) |=> (post))

`endif

>>> rtl/etok_pkg.sv
`default_nettype none

package etok_pkg;

    // Position, text length and token type widths
    localparam int POS_BITS  = 16;
    localparam int LEN_W     = 8;
    localparam int TYPE_W    = 5;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [15:0]         t_opos;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [TYPE_W-1:0]   t_ttype;

    localparam t_pos POS_MAX  = '1;
    localparam t_pos POS_ONE  = t_pos'(1);
    localparam t_len TEXT_CAP = t_len'(255);

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Token type codes
    localparam t_ttype TOK_EOF       = 5'd0;
    localparam t_ttype TOK_IDENT     = 5'd1;
    localparam t_ttype TOK_INT       = 5'd2;
    localparam t_ttype TOK_HEX       = 5'd3;
    localparam t_ttype TOK_STRING    = 5'd4;
    localparam t_ttype TOK_EQ        = 5'd5;
    localparam t_ttype TOK_SEMI      = 5'd6;
    localparam t_ttype TOK_BAR       = 5'd7;
    localparam t_ttype TOK_CONCAT    = 5'd8;
    localparam t_ttype TOK_STAR      = 5'd9;
    localparam t_ttype TOK_ADD       = 5'd10;
    localparam t_ttype TOK_QUEST     = 5'd11;
    localparam t_ttype TOK_EXCEPT    = 5'd12;
    localparam t_ttype TOK_LBRACK    = 5'd13;
    localparam t_ttype TOK_RBRACK    = 5'd14;
    localparam t_ttype TOK_REP_OPEN  = 5'd15;
    localparam t_ttype TOK_REP_CLOSE = 5'd16;
    localparam t_ttype TOK_GRP_OPEN  = 5'd17;
    localparam t_ttype TOK_GRP_CLOSE = 5'd18;
    localparam t_ttype TOK_RANGE     = 5'd19;
    localparam t_ttype TOK_PCT       = 5'd20;
    localparam t_ttype TOK_UNKNOWN   = 5'd21;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_STR,
        M_STR_ESC,
        M_HEX1,
        M_HEX2,
        M_LPAREN,
        M_SLASH,
        M_DOT,
        M_BLOCK,
        M_BLOCK_STAR,
        M_LINE
    } t_mode;

    // One token descriptor
    typedef struct packed {
        t_ttype      token_type;
        t_opos       start_line;
        t_opos       start_column;
        logic [7:0]  text_length;
        logic [15:0] hex_pair;
        logic        last_of_run;
    } t_token;

    // Single-character punctuation; TOK_EOF means "not punctuation"
    function automatic t_ttype single_code(input logic [7:0] c);
        t_ttype code;
        case (c)
            CH_EQ:     code = TOK_EQ;
            CH_SEMI:   code = TOK_SEMI;
            CH_BAR:    code = TOK_BAR;
            CH_COMMA:  code = TOK_CONCAT;
            CH_STAR:   code = TOK_STAR;
            CH_PLUS:   code = TOK_ADD;
            CH_QUEST:  code = TOK_QUEST;
            CH_MINUS:  code = TOK_EXCEPT;
            CH_LBRACK: code = TOK_LBRACK;
            CH_RBRACK: code = TOK_RBRACK;
            CH_LBRACE: code = TOK_REP_OPEN;
            CH_RBRACE: code = TOK_REP_CLOSE;
            CH_RPAREN: code = TOK_GRP_CLOSE;
            CH_PCT:    code = TOK_PCT;
            default:   code = TOK_EOF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/etok_if.sv
`default_nettype none

// Source byte request channel
interface etok_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] source_byte;

    modport source (output valid, action, source_byte, input ready);
    modport sink   (input valid, action, source_byte, output ready);
endinterface

// Token descriptor channel
interface etok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_type;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  text_length;
    logic [15:0] hex_pair;
    logic        last_of_run;

    modport source (output valid, token_type, start_line, start_column, text_length,
                    hex_pair, last_of_run, input ready);
    modport sink   (input valid, token_type, start_line, start_column, text_length,
                    hex_pair, last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/ebnf_tokenizer_core.sv
`default_nettype none

// Streaming EBNF lexer. Takes one source byte (or an end-of-input mark) per
// request on i_req and returns token descriptors on o_tok: type, start line and
// column, text length, and the raw byte pair of a '#' token. A new request is
// taken every clock as long as the 4-entry result queue can absorb two tokens;
// the scanner itself is one mode register plus position and length counters,
// updated in the cycle the registered byte is scanned. Requests pass the input
// register into the result queue feeding o_tok. A byte that ends a pending
// token and starts a new one yields two tokens, and end of input any pending
// token plus EOF; the output port, at one token per clock while o_tok.ready is
// high, sets the sustained rate. After EOF all scanner state is reset.
module ebnf_tokenizer_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    etok_in_if.sink    i_req,
    etok_out_if.source o_tok
);

    // Input stage
    logic       r_in_vld;
    logic       r_in_act;
    logic [7:0] r_in_byte;

    // Scanner state
    etok_pkg::t_mode  r_mode,     n_mode;
    logic             r_quote_sq, n_quote_sq;
    etok_pkg::t_pos   r_line,     n_line;
    etok_pkg::t_pos   r_col,      n_col;
    etok_pkg::t_pos   r_tok_line, n_tok_line;
    etok_pkg::t_pos   r_tok_col,  n_tok_col;
    etok_pkg::t_len   r_len,      n_len;
    logic [7:0]       r_hex,      n_hex;

    // Result queue
    etok_pkg::t_token                r_q [etok_pkg::Q_DEPTH];
    logic [etok_pkg::Q_PTR_W-1:0]    r_wptr;
    logic [etok_pkg::Q_PTR_W-1:0]    r_rptr;
    logic [etok_pkg::Q_CNT_W-1:0]    r_cnt;

    logic pop;
    logic room;
    logic go;

    // Handshakes
    assign pop  = o_tok.valid && o_tok.ready;
    assign room = (r_cnt <= etok_pkg::Q_CNT_W'(2)) ||
                  ((r_cnt == etok_pkg::Q_CNT_W'(3)) && pop);
    assign go   = r_in_vld && room;
    assign i_req.ready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_act  <= i_req.action;
            r_in_byte <= i_req.source_byte;
        end
    end

    // Character classes
    logic [7:0]       c;
    logic             is_alpha;
    logic             is_num;
    logic             is_idch;
    logic             is_ws;
    logic             is_quote;
    etok_pkg::t_ttype sc;

    assign c        = r_in_byte;
    assign is_alpha = ((c >= etok_pkg::CH_UA) && (c <= etok_pkg::CH_UZ)) ||
                      ((c >= etok_pkg::CH_LA) && (c <= etok_pkg::CH_LZ));
    assign is_num   = (c >= etok_pkg::CH_0) && (c <= etok_pkg::CH_9);
    assign is_idch  = is_alpha || (c == etok_pkg::CH_USCORE);
    assign is_ws    = (c == etok_pkg::CH_SPACE) || (c == etok_pkg::CH_TAB) ||
                      (c == etok_pkg::CH_LF) || (c == etok_pkg::CH_CR);
    assign is_quote = r_quote_sq ? (c == etok_pkg::CH_SQUOTE) : (c == etok_pkg::CH_DQUOTE);
    assign sc       = etok_pkg::single_code(c);

    // Decode of a byte seen from idle
    etok_pkg::t_mode  idle_mode;
    logic             idle_emit;
    etok_pkg::t_ttype idle_type;
    logic             idle_len_set;
    etok_pkg::t_len   idle_len;
    logic             idle_quote_set;

    always_comb begin
        idle_mode      = etok_pkg::M_IDLE;
        idle_emit      = 1'b0;
        idle_type      = etok_pkg::TOK_UNKNOWN;
        idle_len_set   = 1'b0;
        idle_len       = '0;
        idle_quote_set = 1'b0;
        if (is_ws) begin
            idle_mode = etok_pkg::M_IDLE;
        end else if (c == etok_pkg::CH_LPAREN) begin
            idle_mode = etok_pkg::M_LPAREN;
        end else if (c == etok_pkg::CH_SLASH) begin
            idle_mode = etok_pkg::M_SLASH;
        end else if (c == etok_pkg::CH_DOT) begin
            idle_mode = etok_pkg::M_DOT;
        end else if (sc != etok_pkg::TOK_EOF) begin
            idle_emit = 1'b1;
            idle_type = sc;
        end else if (c == etok_pkg::CH_HASH) begin
            idle_mode = etok_pkg::M_HEX1;
        end else if (is_idch) begin
            idle_mode    = etok_pkg::M_IDENT;
            idle_len_set = 1'b1;
            idle_len     = etok_pkg::t_len'(1);
        end else if (is_num) begin
            idle_mode    = etok_pkg::M_INT;
            idle_len_set = 1'b1;
            idle_len     = etok_pkg::t_len'(1);
        end else if ((c == etok_pkg::CH_DQUOTE) || (c == etok_pkg::CH_SQUOTE)) begin
            idle_mode      = etok_pkg::M_STR;
            idle_len_set   = 1'b1;
            idle_quote_set = 1'b1;
        end else begin
            idle_emit = 1'b1;
        end
    end

    // Mode flow: pending token, relex from idle, held mode
    logic             pend_emit;
    etok_pkg::t_ttype pend_type;
    etok_pkg::t_len   pend_len;
    logic [15:0]      pend_pair;
    logic             run_idle;
    etok_pkg::t_mode  hold_mode;
    logic             grow_len;
    logic             load_hex;

    always_comb begin
        pend_emit = 1'b0;
        pend_type = etok_pkg::TOK_UNKNOWN;
        pend_len  = etok_pkg::t_len'(1);
        pend_pair = '0;
        run_idle  = 1'b0;
        hold_mode = r_mode;
        grow_len  = 1'b0;
        load_hex  = 1'b0;
        if (r_in_act) begin
            // end of input: flush whatever is pending
            unique case (r_mode)
                etok_pkg::M_IDENT: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_IDENT;
                    pend_len  = r_len;
                end
                etok_pkg::M_INT: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_INT;
                    pend_len  = r_len;
                end
                etok_pkg::M_STR, etok_pkg::M_STR_ESC: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_STRING;
                    pend_len  = r_len;
                end
                etok_pkg::M_HEX1: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_HEX;
                end
                etok_pkg::M_HEX2: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_HEX;
                    pend_len  = etok_pkg::t_len'(2);
                    pend_pair = {r_hex, 8'h00};
                end
                etok_pkg::M_LPAREN: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_GRP_OPEN;
                end
                etok_pkg::M_SLASH, etok_pkg::M_DOT: begin
                    pend_emit = 1'b1;
                end
                default: begin
                    pend_emit = 1'b0;
                end
            endcase
        end else begin
            unique case (r_mode)
                etok_pkg::M_IDENT, etok_pkg::M_INT: begin
                    if (is_num || ((r_mode == etok_pkg::M_IDENT) && is_idch)) begin
                        grow_len = 1'b1;
                    end else begin
                        pend_emit = 1'b1;
                        pend_type = (r_mode == etok_pkg::M_IDENT) ? etok_pkg::TOK_IDENT
                                                                  : etok_pkg::TOK_INT;
                        pend_len  = r_len;
                        run_idle  = 1'b1;
                    end
                end
                etok_pkg::M_STR: begin
                    if (is_quote) begin
                        pend_emit = 1'b1;
                        pend_type = etok_pkg::TOK_STRING;
                        pend_len  = r_len;
                        hold_mode = etok_pkg::M_IDLE;
                    end else begin
                        grow_len = 1'b1;
                        if (c == etok_pkg::CH_BSLASH) begin
                            hold_mode = etok_pkg::M_STR_ESC;
                        end
                    end
                end
                etok_pkg::M_STR_ESC: begin
                    grow_len  = 1'b1;
                    hold_mode = etok_pkg::M_STR;
                end
                etok_pkg::M_HEX1: begin
                    load_hex  = 1'b1;
                    hold_mode = etok_pkg::M_HEX2;
                end
                etok_pkg::M_HEX2: begin
                    pend_emit = 1'b1;
                    pend_type = etok_pkg::TOK_HEX;
                    pend_len  = etok_pkg::t_len'(3);
                    pend_pair = {r_hex, c};
                    hold_mode = etok_pkg::M_IDLE;
                end
                etok_pkg::M_LPAREN: begin
                    if (c == etok_pkg::CH_STAR) begin
                        hold_mode = etok_pkg::M_BLOCK;
                    end else begin
                        pend_emit = 1'b1;
                        pend_type = etok_pkg::TOK_GRP_OPEN;
                        run_idle  = 1'b1;
                    end
                end
                etok_pkg::M_SLASH: begin
                    if (c == etok_pkg::CH_SLASH) begin
                        hold_mode = etok_pkg::M_LINE;
                    end else begin
                        pend_emit = 1'b1;
                        run_idle  = 1'b1;
                    end
                end
                etok_pkg::M_DOT: begin
                    pend_emit = 1'b1;
                    if (c == etok_pkg::CH_DOT) begin
                        pend_type = etok_pkg::TOK_RANGE;
                        pend_len  = etok_pkg::t_len'(2);
                        hold_mode = etok_pkg::M_IDLE;
                    end else begin
                        run_idle = 1'b1;
                    end
                end
                etok_pkg::M_BLOCK: begin
                    if (c == etok_pkg::CH_STAR) begin
                        hold_mode = etok_pkg::M_BLOCK_STAR;
                    end
                end
                etok_pkg::M_BLOCK_STAR: begin
                    if (c == etok_pkg::CH_RPAREN) begin
                        hold_mode = etok_pkg::M_IDLE;
                    end else if (c != etok_pkg::CH_STAR) begin
                        hold_mode = etok_pkg::M_BLOCK;
                    end
                end
                etok_pkg::M_LINE: begin
                    // newline ends the comment and is then seen from idle
                    if (c == etok_pkg::CH_LF) begin
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_mode     = r_mode;
        n_quote_sq = r_quote_sq;
        n_line     = r_line;
        n_col      = r_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_len      = r_len;
        n_hex      = r_hex;
        if (go) begin
            if (r_in_act) begin
                n_mode     = etok_pkg::M_IDLE;
                n_quote_sq = 1'b0;
                n_line     = etok_pkg::POS_ONE;
                n_col      = etok_pkg::POS_ONE;
                n_tok_line = etok_pkg::POS_ONE;
                n_tok_col  = etok_pkg::POS_ONE;
                n_len      = '0;
                n_hex      = '0;
            end else begin
                // position advances once per byte, saturating
                if (c == etok_pkg::CH_LF) begin
                    if (r_line < etok_pkg::POS_MAX) begin
                        n_line = r_line + etok_pkg::POS_ONE;
                    end
                    n_col = etok_pkg::POS_ONE;
                end else if (r_col < etok_pkg::POS_MAX) begin
                    n_col = r_col + etok_pkg::POS_ONE;
                end
                if (run_idle) begin
                    n_mode     = idle_mode;
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    if (idle_len_set) begin
                        n_len = idle_len;
                    end
                    if (idle_quote_set) begin
                        n_quote_sq = (c == etok_pkg::CH_SQUOTE);
                    end
                end else begin
                    n_mode = hold_mode;
                    if (grow_len && (r_len < etok_pkg::TEXT_CAP)) begin
                        n_len = r_len + etok_pkg::t_len'(1);
                    end
                    if (load_hex) begin
                        n_hex = c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= etok_pkg::M_IDLE;
            r_quote_sq <= 1'b0;
            r_line     <= etok_pkg::POS_ONE;
            r_col      <= etok_pkg::POS_ONE;
            r_tok_line <= etok_pkg::POS_ONE;
            r_tok_col  <= etok_pkg::POS_ONE;
            r_len      <= '0;
            r_hex      <= '0;
        end else begin
            r_mode     <= n_mode;
            r_quote_sq <= n_quote_sq;
            r_line     <= n_line;
            r_col      <= n_col;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_len      <= n_len;
            r_hex      <= n_hex;
        end
    end

    // Result assembly: token A at the pending start, token B at the current position
    logic             emit_b;
    logic [1:0]       n_res;
    etok_pkg::t_token tok_a;
    etok_pkg::t_token tok_b;
    etok_pkg::t_token res0;
    etok_pkg::t_token res1;

    always_comb begin
        emit_b = r_in_act || (run_idle && idle_emit);
        n_res  = {1'b0, pend_emit} + {1'b0, emit_b};

        tok_a.token_type   = pend_type;
        tok_a.start_line   = etok_pkg::t_opos'(r_tok_line);
        tok_a.start_column = etok_pkg::t_opos'(r_tok_col);
        tok_a.text_length  = 8'(pend_len);
        tok_a.hex_pair     = pend_pair;
        tok_a.last_of_run  = !emit_b;

        tok_b.token_type   = r_in_act ? etok_pkg::TOK_EOF : idle_type;
        tok_b.start_line   = etok_pkg::t_opos'(r_line);
        tok_b.start_column = etok_pkg::t_opos'(r_col);
        tok_b.text_length  = r_in_act ? 8'd0 : 8'd1;
        tok_b.hex_pair     = '0;
        tok_b.last_of_run  = 1'b1;

        res0 = pend_emit ? tok_a : tok_b;
        res1 = tok_b;
    end

    // Result queue
    always_ff @(posedge i_clk) begin
        if (go && (n_res != 2'd0)) begin
            r_q[r_wptr] <= res0;
            if (n_res == 2'd2) begin
                r_q[r_wptr + etok_pkg::Q_PTR_W'(1)] <= res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (go) begin
                r_wptr <= r_wptr + etok_pkg::Q_PTR_W'(n_res);
            end
            if (pop) begin
                r_rptr <= r_rptr + etok_pkg::Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + (go ? etok_pkg::Q_CNT_W'(n_res) : '0)
                           - etok_pkg::Q_CNT_W'(pop);
        end
    end

    assign o_tok.valid        = (r_cnt != '0);
    assign o_tok.token_type   = r_q[r_rptr].token_type;
    assign o_tok.start_line   = r_q[r_rptr].start_line;
    assign o_tok.start_column = r_q[r_rptr].start_column;
    assign o_tok.text_length  = r_q[r_rptr].text_length;
    assign o_tok.hex_pair     = r_q[r_rptr].hex_pair;
    assign o_tok.last_of_run  = r_q[r_rptr].last_of_run;

endmodule

`default_nettype wire

>>> rtl/etok_checker.sv
`default_nettype none

`include "assert_macros.svh"

module etok_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [4:0]  i_token_type,
    input wire [15:0] i_start_line,
    input wire [15:0] i_start_column,
    input wire [7:0]  i_text_length,
    input wire [15:0] i_hex_pair,
    input wire        i_last_of_run
);

    // Queue comes out of reset empty
    `AST_CHK(a_empty_after_reset, $rose(i_rst_n) |-> !i_out_valid)

    // EOF is zero length and always closes its run
    `AST_CHK(a_eof_shape, (i_out_valid && (i_token_type == etok_pkg::TOK_EOF)) |-> ((i_text_length == 8'd0) && i_last_of_run))

    // Byte pair only carried on hex tokens
    `AST_CHK(a_pair_hex_only, (i_out_valid && (i_token_type != etok_pkg::TOK_HEX)) |-> (i_hex_pair == 16'd0))

    // Positions count from one
    `AST_CHK(a_pos_nonzero, i_out_valid |-> ((i_start_line != 16'd0) && (i_start_column != 16'd0)))

    // Stalled token holds its type, start column and length
    `AST_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_token_type) && $stable(i_start_column) && $stable(i_text_length))

endmodule

bind ebnf_tokenizer_core etok_checker u_etok_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_tok.valid),
    .i_out_ready    (o_tok.ready),
    .i_token_type   (o_tok.token_type),
    .i_start_line   (o_tok.start_line),
    .i_start_column (o_tok.start_column),
    .i_text_length  (o_tok.text_length),
    .i_hex_pair     (o_tok.hex_pair),
    .i_last_of_run  (o_tok.last_of_run)
);

`default_nettype wire
